// File: hw/rtl/rcpcs_pkg.sv
package rcpcs_pkg;

  // Field and datapath widths
  localparam int unsigned KindW   = 3;
  localparam int unsigned ChW     = 2;
  localparam int unsigned WidthW  = 16;
  localparam int unsigned NumCh   = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned AxisW   = 8;
  localparam int unsigned SumW    = 32;
  localparam int unsigned CntW    = 16;
  localparam int unsigned ValW    = WidthW + 1;   // centered value, signed
  localparam int unsigned ProdW   = 2 * ValW;     // signed product
  localparam int unsigned MagW    = 32;           // product magnitude / divider dividend
  localparam int unsigned PcW     = 5;

  // Reset values
  localparam logic [WidthW-1:0] MinReset     = 16'd2000;
  localparam logic [CfgW-1:0]   SpanLoReset  = 16'd400;
  localparam logic [CfgW-1:0]   SpanHiReset  = 16'd1100;
  localparam logic [CfgW-1:0]   ThrNumReset  = 16'd255;
  localparam logic [CfgW-1:0]   ThrDenReset  = 16'd1000;
  localparam logic [AxisW-1:0]  RollNumReset = 8'd60;
  localparam logic [AxisW-1:0]  PitchNumReset = 8'd40;
  localparam logic [AxisW-1:0]  YawNumReset  = 8'd30;
  localparam logic [CfgW-1:0]   AxisDenReset = 16'd400;

  typedef enum logic [KindW-1:0] {
    KIND_PULSE       = 3'd0,
    KIND_BOUND_START = 3'd1,
    KIND_BOUND_STOP  = 3'd2,
    KIND_AVG_START   = 3'd3,
    KIND_AVG_STOP    = 3'd4
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPAN_LO   = 3'd0,
    CFG_SPAN_HI   = 3'd1,
    CFG_THR_NUM   = 3'd2,
    CFG_THR_DEN   = 3'd3,
    CFG_ROLL_NUM  = 3'd4,
    CFG_PITCH_NUM = 3'd5,
    CFG_YAW_NUM   = 3'd6,
    CFG_AXIS_DEN  = 3'd7
  } cfg_e;

  typedef enum logic [ChW-1:0] {
    CH_THROTTLE = 2'd0,
    CH_ROLL     = 2'd1,
    CH_PITCH    = 2'd2,
    CH_YAW      = 2'd3
  } chan_e;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    UOP_NOP,
    UOP_LOAD,
    UOP_BOUND,
    UOP_AVG,
    UOP_CLAMP,
    UOP_MUL,
    UOP_DIV_SCALE,
    UOP_SCALE,
    UOP_EMIT_REF,
    UOP_BSET,
    UOP_SPAN_INIT,
    UOP_SPAN,
    UOP_EMIT_VERDICT,
    UOP_ASET,
    UOP_ASTOP,
    UOP_DIV_CENTER,
    UOP_CENTER_STORE
  } uop_e;

  // Sequencer branch conditions
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_GOTO,
    COND_WAIT_IN,
    COND_DISPATCH,
    COND_WAIT_DIV,
    COND_WAIT_OUT,
    COND_LOOP
  } cond_e;

  typedef struct packed {
    uop_e           op;
    cond_e          cond;
    logic [PcW-1:0] target;
  } ctrl_t;

  // Program addresses
  localparam logic [PcW-1:0] PC_FETCH   = 5'd0;
  localparam logic [PcW-1:0] PC_DECODE  = 5'd1;
  localparam logic [PcW-1:0] PC_BOUND   = 5'd2;
  localparam logic [PcW-1:0] PC_AVG     = 5'd3;
  localparam logic [PcW-1:0] PC_CLAMP   = 5'd4;
  localparam logic [PcW-1:0] PC_MUL     = 5'd5;
  localparam logic [PcW-1:0] PC_DIVS    = 5'd6;
  localparam logic [PcW-1:0] PC_DIVW    = 5'd7;
  localparam logic [PcW-1:0] PC_SCALE   = 5'd8;
  localparam logic [PcW-1:0] PC_EMITR   = 5'd9;
  localparam logic [PcW-1:0] PC_BSET    = 5'd10;
  localparam logic [PcW-1:0] PC_SPAN0   = 5'd11;
  localparam logic [PcW-1:0] PC_SPAN    = 5'd12;
  localparam logic [PcW-1:0] PC_EMITV   = 5'd13;
  localparam logic [PcW-1:0] PC_ASET    = 5'd14;
  localparam logic [PcW-1:0] PC_ASTOP   = 5'd15;
  localparam logic [PcW-1:0] PC_CDIVS   = 5'd16;
  localparam logic [PcW-1:0] PC_CDIVW   = 5'd17;
  localparam logic [PcW-1:0] PC_CSTORE  = 5'd18;
  localparam logic [PcW-1:0] PC_CDONE   = 5'd19;

  // Control store
  function automatic ctrl_t ucode(logic [PcW-1:0] pc);
    ctrl_t cw;
    cw = '{op: UOP_NOP, cond: COND_GOTO, target: PC_FETCH};
    case (pc)
      PC_FETCH:  cw = '{op: UOP_LOAD,         cond: COND_WAIT_IN,  target: PC_DECODE};
      PC_DECODE: cw = '{op: UOP_NOP,          cond: COND_DISPATCH, target: PC_FETCH};
      PC_BOUND:  cw = '{op: UOP_BOUND,        cond: COND_GOTO,     target: PC_FETCH};
      PC_AVG:    cw = '{op: UOP_AVG,          cond: COND_GOTO,     target: PC_FETCH};
      PC_CLAMP:  cw = '{op: UOP_CLAMP,        cond: COND_NEXT,     target: PC_FETCH};
      PC_MUL:    cw = '{op: UOP_MUL,          cond: COND_NEXT,     target: PC_FETCH};
      PC_DIVS:   cw = '{op: UOP_DIV_SCALE,    cond: COND_NEXT,     target: PC_FETCH};
      PC_DIVW:   cw = '{op: UOP_NOP,          cond: COND_WAIT_DIV, target: PC_FETCH};
      PC_SCALE:  cw = '{op: UOP_SCALE,        cond: COND_NEXT,     target: PC_FETCH};
      PC_EMITR:  cw = '{op: UOP_EMIT_REF,     cond: COND_WAIT_OUT, target: PC_FETCH};
      PC_BSET:   cw = '{op: UOP_BSET,         cond: COND_GOTO,     target: PC_FETCH};
      PC_SPAN0:  cw = '{op: UOP_SPAN_INIT,    cond: COND_NEXT,     target: PC_FETCH};
      PC_SPAN:   cw = '{op: UOP_SPAN,         cond: COND_LOOP,     target: PC_SPAN};
      PC_EMITV:  cw = '{op: UOP_EMIT_VERDICT, cond: COND_WAIT_OUT, target: PC_FETCH};
      PC_ASET:   cw = '{op: UOP_ASET,         cond: COND_GOTO,     target: PC_FETCH};
      PC_ASTOP:  cw = '{op: UOP_ASTOP,        cond: COND_NEXT,     target: PC_FETCH};
      PC_CDIVS:  cw = '{op: UOP_DIV_CENTER,   cond: COND_NEXT,     target: PC_FETCH};
      PC_CDIVW:  cw = '{op: UOP_NOP,          cond: COND_WAIT_DIV, target: PC_FETCH};
      PC_CSTORE: cw = '{op: UOP_CENTER_STORE, cond: COND_LOOP,     target: PC_CDIVS};
      PC_CDONE:  cw = '{op: UOP_NOP,          cond: COND_GOTO,     target: PC_FETCH};
      default:   cw = '{op: UOP_NOP,          cond: COND_GOTO,     target: PC_FETCH};
    endcase
    return cw;
  endfunction

endpackage

// File: hw/rtl/rcpcs_div.sv
module rcpcs_div #(
  parameter int unsigned DividendW = rcpcs_pkg::MagW,
  parameter int unsigned DivisorW  = rcpcs_pkg::WidthW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 busy_o,
  output logic [DividendW-1:0] quotient_o
);

  localparam int unsigned StepW = $clog2(DividendW);

  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  den_q, den_d;
  logic [StepW-1:0]     cnt_q, cnt_d;
  logic                 busy_q, busy_d;

  logic [DivisorW:0] rem_sh;
  logic [DivisorW:0] diff;
  logic              fits;

  // Restoring division, one quotient bit per cycle
  assign rem_sh = {rem_q, quo_q[DividendW-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign fits   = ~diff[DivisorW];

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
      cnt_d  = StepW'(DividendW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DividendW-2:0], fits};
      rem_d = fits ? diff[DivisorW-1:0] : rem_sh[DivisorW-1:0];
      cnt_d = cnt_q - StepW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// File: hw/rtl/rc_pulse_calibrate_and_scale.sv
// Channel  | Signals                                        | Moves
// ---------+------------------------------------------------+--------------------------------
// in       | in_valid_i / in_ready_o, kind_i, channel_i,    | one pulse width or calibration
//          | width_i                                        | command per transaction
// out      | out_valid_o / out_ready_i, result_kind_o,      | one scaled reference or one
//          | out_channel_o, reference_o, bounds_ok_o        | bounds verdict per transaction
// cfg      | cfg_we_i, cfg_idx_i, cfg_wdata_i               | register write, no wait
//
// A microcoded sequencer steps through a small control store; one command at a time.
// A normal pulse spends most of its time from acceptance to result in the bit-serial
// divider. Stop averaging runs one division per axis (roll, pitch, yaw), and stop
// bounds checks the span of every channel.
// Reset loads all calibration state at once; there is no clearing pass.
// A result waiting in the output register stalls the sequencer only at its emit step.
module rc_pulse_calibrate_and_scale (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input transactions
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rcpcs_pkg::KindW-1:0]         kind_i,
  input  logic [rcpcs_pkg::ChW-1:0]           channel_i,
  input  logic [rcpcs_pkg::WidthW-1:0]        width_i,
  // output transactions
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                result_kind_o,
  output logic [rcpcs_pkg::ChW-1:0]           out_channel_o,
  output logic signed [rcpcs_pkg::WidthW-1:0] reference_o,
  output logic                                bounds_ok_o,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [rcpcs_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [rcpcs_pkg::CfgW-1:0]          cfg_wdata_i
);

  localparam int unsigned PcW    = rcpcs_pkg::PcW;
  localparam int unsigned ChW    = rcpcs_pkg::ChW;
  localparam int unsigned WidthW = rcpcs_pkg::WidthW;
  localparam int unsigned NumCh  = rcpcs_pkg::NumCh;
  localparam int unsigned ValW   = rcpcs_pkg::ValW;
  localparam int unsigned ProdW  = rcpcs_pkg::ProdW;
  localparam int unsigned MagW   = rcpcs_pkg::MagW;
  localparam int unsigned SumW   = rcpcs_pkg::SumW;
  localparam int unsigned CntW   = rcpcs_pkg::CntW;
  localparam int unsigned CfgW   = rcpcs_pkg::CfgW;
  localparam int unsigned AxisW  = rcpcs_pkg::AxisW;
  localparam int unsigned KindW  = rcpcs_pkg::KindW;

  // Sequencer
  logic [PcW-1:0]   pc_q, pc_d, pc_inc, dispatch_pc;
  rcpcs_pkg::ctrl_t cw;

  // Command latch and datapath registers
  logic [KindW-1:0]        kind_q, kind_d;
  logic [WidthW-1:0]       w_q, w_d;
  logic [ChW-1:0]          idx_q, idx_d;
  logic signed [ValW-1:0]  acc_q, acc_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic                    neg_q, neg_d;
  logic [WidthW-1:0]       ref_q, ref_d;
  logic                    ok_q, ok_d;
  logic                    bmode_q, bmode_d;
  logic                    amode_q, amode_d;

  // Calibration state
  logic [WidthW-1:0] max_q [NumCh];
  logic [WidthW-1:0] max_d [NumCh];
  logic [WidthW-1:0] min_q [NumCh];
  logic [WidthW-1:0] min_d [NumCh];
  logic [SumW-1:0]   sum_q [NumCh];
  logic [SumW-1:0]   sum_d [NumCh];
  logic [CntW-1:0]   cnt_q [NumCh];
  logic [CntW-1:0]   cnt_d [NumCh];
  logic [WidthW-1:0] ctr_q [NumCh];
  logic [WidthW-1:0] ctr_d [NumCh];
  logic [WidthW-1:0] last_q [NumCh];
  logic [WidthW-1:0] last_d [NumCh];

  // Configuration registers
  logic [CfgW-1:0]  span_lo_q, span_lo_d;
  logic [CfgW-1:0]  span_hi_q, span_hi_d;
  logic [CfgW-1:0]  thr_num_q, thr_num_d;
  logic [CfgW-1:0]  thr_den_q, thr_den_d;
  logic [AxisW-1:0] roll_num_q, roll_num_d;
  logic [AxisW-1:0] pitch_num_q, pitch_num_d;
  logic [AxisW-1:0] yaw_num_q, yaw_num_d;
  logic [CfgW-1:0]  axis_den_q, axis_den_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic              res_kind_q, res_kind_d;
  logic [ChW-1:0]    out_ch_q, out_ch_d;
  logic [WidthW-1:0] out_ref_q, out_ref_d;
  logic              out_ok_q, out_ok_d;

  // Datapath combinational values
  logic [WidthW-1:0]       cur_max, cur_min, cur_ctr, cur_last;
  logic [SumW-1:0]         cur_sum;
  logic [CntW-1:0]         cur_cnt;
  logic                    is_thr;
  logic                    repeat_hit;
  logic [WidthW-1:0]       clamped, base;
  logic signed [ValW-1:0]  centered;
  logic [CfgW-1:0]         num_sel, den_sel, den_nz;
  logic signed [ProdW-1:0] prod_full, prod_neg;
  logic [MagW-1:0]         prod_mag;
  logic [WidthW-1:0]       acc_sat;
  logic signed [ValW-1:0]  span;
  logic                    span_bad;
  logic [WidthW-1:0]       q_neg;
  logic [WidthW-1:0]       scaled;
  logic                    in_fire, out_free;

  // Divider
  logic                div_start, div_busy;
  logic [MagW-1:0]     div_dividend, div_q;
  logic [WidthW-1:0]   div_divisor;

  assign cw = rcpcs_pkg::ucode(pc_q);

  assign in_ready_o = (cw.op == rcpcs_pkg::UOP_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // All state arrays are addressed through the single channel pointer
  assign cur_max  = max_q[idx_q];
  assign cur_min  = min_q[idx_q];
  assign cur_ctr  = ctr_q[idx_q];
  assign cur_last = last_q[idx_q];
  assign cur_sum  = sum_q[idx_q];
  assign cur_cnt  = cnt_q[idx_q];
  assign is_thr   = (idx_q == rcpcs_pkg::CH_THROTTLE);

  // A width equal to the channel's stored last value is dropped, unless it is negative
  assign repeat_hit = (w_q == cur_last) && !cur_last[WidthW-1];

  // Clamp tests max first: in an inverted window only widths at or above max land on max
  assign clamped = (w_q >= cur_max) ? cur_max : ((w_q <= cur_min) ? cur_min : w_q);
  assign base    = is_thr ? cur_min : cur_ctr;
  assign centered = signed'({1'b0, clamped}) - signed'({1'b0, base});

  always_comb begin
    case (idx_q)
      rcpcs_pkg::CH_THROTTLE: num_sel = thr_num_q;
      rcpcs_pkg::CH_ROLL:     num_sel = {{(CfgW-AxisW){1'b0}}, roll_num_q};
      rcpcs_pkg::CH_PITCH:    num_sel = {{(CfgW-AxisW){1'b0}}, pitch_num_q};
      rcpcs_pkg::CH_YAW:      num_sel = {{(CfgW-AxisW){1'b0}}, yaw_num_q};
      default:                num_sel = '0;
    endcase
  end

  assign den_sel   = is_thr ? thr_den_q : axis_den_q;
  assign den_nz    = (den_sel == '0) ? CfgW'(1) : den_sel;
  assign prod_full = acc_q * signed'({1'b0, num_sel});
  assign prod_neg  = -prod_q;
  assign prod_mag  = prod_q[ProdW-1] ? prod_neg[MagW-1:0] : prod_q[MagW-1:0];

  // Saturate the centered value to 16 bits signed
  assign acc_sat = (acc_q[ValW-1] != acc_q[ValW-2]) ?
                   (acc_q[ValW-1] ? {1'b1, {(WidthW-1){1'b0}}} : {1'b0, {(WidthW-1){1'b1}}}) :
                   acc_q[WidthW-1:0];

  assign span     = signed'({1'b0, cur_max}) - signed'({1'b0, cur_min});
  assign span_bad = (span < signed'({1'b0, span_lo_q})) || (span > signed'({1'b0, span_hi_q}));

  // Sign and saturate the quotient magnitude
  assign q_neg = -div_q[WidthW-1:0];
  always_comb begin
    if (is_thr) begin
      if (neg_q) begin
        scaled = '0;
      end else if (div_q > MagW'(255)) begin
        scaled = WidthW'(255);
      end else begin
        scaled = {{(WidthW-8){1'b0}}, div_q[7:0]};
      end
    end else if (neg_q) begin
      scaled = (div_q > MagW'(32768)) ? {1'b1, {(WidthW-1){1'b0}}} : q_neg;
    end else begin
      scaled = (div_q > MagW'(32767)) ? {1'b0, {(WidthW-1){1'b1}}} : div_q[WidthW-1:0];
    end
  end

  // Divider operand select
  assign div_start    = (cw.op == rcpcs_pkg::UOP_DIV_SCALE) ||
                        (cw.op == rcpcs_pkg::UOP_DIV_CENTER);
  assign div_dividend = (cw.op == rcpcs_pkg::UOP_DIV_CENTER) ? cur_sum : prod_mag;
  assign div_divisor  = (cw.op == rcpcs_pkg::UOP_DIV_CENTER) ?
                        ((cur_cnt == '0) ? WidthW'(1) : cur_cnt) : den_nz;

  rcpcs_div #(
    .DividendW(MagW),
    .DivisorW (WidthW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .busy_o    (div_busy),
    .quotient_o(div_q)
  );

  // Decode: pick the routine for the latched command
  always_comb begin
    case (kind_q)
      rcpcs_pkg::KIND_PULSE: begin
        if (repeat_hit) begin
          dispatch_pc = rcpcs_pkg::PC_FETCH;
        end else if (bmode_q) begin
          dispatch_pc = rcpcs_pkg::PC_BOUND;
        end else if (amode_q && !is_thr) begin
          dispatch_pc = rcpcs_pkg::PC_AVG;
        end else begin
          dispatch_pc = rcpcs_pkg::PC_CLAMP;
        end
      end
      rcpcs_pkg::KIND_BOUND_START: dispatch_pc = rcpcs_pkg::PC_BSET;
      rcpcs_pkg::KIND_BOUND_STOP:  dispatch_pc = rcpcs_pkg::PC_SPAN0;
      rcpcs_pkg::KIND_AVG_START:   dispatch_pc = rcpcs_pkg::PC_ASET;
      rcpcs_pkg::KIND_AVG_STOP:    dispatch_pc = rcpcs_pkg::PC_ASTOP;
      default:                     dispatch_pc = rcpcs_pkg::PC_FETCH;
    endcase
  end

  // Step counter with conditional jumps
  assign pc_inc = pc_q + PcW'(1);
  always_comb begin
    case (cw.cond)
      rcpcs_pkg::COND_NEXT:     pc_d = pc_inc;
      rcpcs_pkg::COND_GOTO:     pc_d = cw.target;
      rcpcs_pkg::COND_WAIT_IN:  pc_d = in_valid_i ? cw.target : pc_q;
      rcpcs_pkg::COND_DISPATCH: pc_d = dispatch_pc;
      rcpcs_pkg::COND_WAIT_DIV: pc_d = div_busy ? pc_q : pc_inc;
      rcpcs_pkg::COND_WAIT_OUT: pc_d = out_free ? cw.target : pc_q;
      rcpcs_pkg::COND_LOOP:     pc_d = (idx_q != {ChW{1'b1}}) ? cw.target : pc_inc;
      default:                  pc_d = rcpcs_pkg::PC_FETCH;
    endcase
  end

  // Datapath actions of each control word
  always_comb begin
    kind_d  = kind_q;
    w_d     = w_q;
    idx_d   = idx_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    neg_d   = neg_q;
    ref_d   = ref_q;
    ok_d    = ok_q;
    bmode_d = bmode_q;
    amode_d = amode_q;
    max_d   = max_q;
    min_d   = min_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    ctr_d   = ctr_q;
    last_d  = last_q;

    // drop the held result once the transaction completes
    out_valid_d = out_valid_q && !out_ready_i;
    res_kind_d  = res_kind_q;
    out_ch_d    = out_ch_q;
    out_ref_d   = out_ref_q;
    out_ok_d    = out_ok_q;

    case (cw.op)
      rcpcs_pkg::UOP_LOAD: begin
        if (in_fire) begin
          kind_d = kind_i;
          w_d    = width_i;
          idx_d  = channel_i;
        end
      end
      rcpcs_pkg::UOP_BOUND: begin
        if (w_q > cur_max) begin
          max_d[idx_q] = w_q;
        end
        if (w_q < cur_min) begin
          min_d[idx_q] = w_q;
        end
      end
      rcpcs_pkg::UOP_AVG: begin
        if (cur_cnt != {CntW{1'b1}}) begin
          sum_d[idx_q] = cur_sum + {{(SumW-WidthW){1'b0}}, w_q};
          cnt_d[idx_q] = cur_cnt + CntW'(1);
        end
      end
      rcpcs_pkg::UOP_CLAMP: begin
        acc_d = centered;
      end
      rcpcs_pkg::UOP_MUL: begin
        prod_d = prod_full;
        // throttle remembers its centered value before scaling
        if (is_thr) begin
          last_d[idx_q] = acc_sat;
        end
      end
      rcpcs_pkg::UOP_DIV_SCALE: begin
        neg_d = prod_q[ProdW-1];
      end
      rcpcs_pkg::UOP_SCALE: begin
        ref_d = scaled;
        if (!is_thr) begin
          last_d[idx_q] = scaled;
        end
      end
      rcpcs_pkg::UOP_EMIT_REF: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          res_kind_d  = 1'b0;
          out_ch_d    = idx_q;
          out_ref_d   = ref_q;
          out_ok_d    = 1'b0;
        end
      end
      rcpcs_pkg::UOP_BSET: begin
        bmode_d = 1'b1;
      end
      rcpcs_pkg::UOP_SPAN_INIT: begin
        idx_d = rcpcs_pkg::CH_THROTTLE;
        ok_d  = 1'b1;
      end
      rcpcs_pkg::UOP_SPAN: begin
        ok_d  = ok_q && !span_bad;
        idx_d = idx_q + ChW'(1);
      end
      rcpcs_pkg::UOP_EMIT_VERDICT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          res_kind_d  = 1'b1;
          out_ch_d    = rcpcs_pkg::CH_THROTTLE;
          out_ref_d   = '0;
          out_ok_d    = ok_q;
          // leave boundary mode only on pass
          if (ok_q) begin
            bmode_d = 1'b0;
          end
        end
      end
      rcpcs_pkg::UOP_ASET: begin
        amode_d = 1'b1;
      end
      rcpcs_pkg::UOP_ASTOP: begin
        amode_d = 1'b0;
        idx_d   = rcpcs_pkg::CH_ROLL;
      end
      rcpcs_pkg::UOP_CENTER_STORE: begin
        // a channel with no samples keeps its old center
        if (cur_cnt != '0) begin
          ctr_d[idx_q] = div_q[WidthW-1:0];
        end
        idx_d = idx_q + ChW'(1);
      end
      default: begin
      end
    endcase
  end

  // Configuration writes
  always_comb begin
    span_lo_d   = span_lo_q;
    span_hi_d   = span_hi_q;
    thr_num_d   = thr_num_q;
    thr_den_d   = thr_den_q;
    roll_num_d  = roll_num_q;
    pitch_num_d = pitch_num_q;
    yaw_num_d   = yaw_num_q;
    axis_den_d  = axis_den_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rcpcs_pkg::CFG_SPAN_LO:   span_lo_d   = cfg_wdata_i;
        rcpcs_pkg::CFG_SPAN_HI:   span_hi_d   = cfg_wdata_i;
        rcpcs_pkg::CFG_THR_NUM:   thr_num_d   = cfg_wdata_i;
        rcpcs_pkg::CFG_THR_DEN:   thr_den_d   = cfg_wdata_i;
        rcpcs_pkg::CFG_ROLL_NUM:  roll_num_d  = cfg_wdata_i[AxisW-1:0];
        rcpcs_pkg::CFG_PITCH_NUM: pitch_num_d = cfg_wdata_i[AxisW-1:0];
        rcpcs_pkg::CFG_YAW_NUM:   yaw_num_d   = cfg_wdata_i[AxisW-1:0];
        rcpcs_pkg::CFG_AXIS_DEN:  axis_den_d  = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= rcpcs_pkg::PC_FETCH;
      idx_q       <= '0;
      ok_q        <= 1'b0;
      bmode_q     <= 1'b0;
      amode_q     <= 1'b0;
      out_valid_q <= 1'b0;
      span_lo_q   <= rcpcs_pkg::SpanLoReset;
      span_hi_q   <= rcpcs_pkg::SpanHiReset;
      thr_num_q   <= rcpcs_pkg::ThrNumReset;
      thr_den_q   <= rcpcs_pkg::ThrDenReset;
      roll_num_q  <= rcpcs_pkg::RollNumReset;
      pitch_num_q <= rcpcs_pkg::PitchNumReset;
      yaw_num_q   <= rcpcs_pkg::YawNumReset;
      axis_den_q  <= rcpcs_pkg::AxisDenReset;
      for (int i = 0; i < NumCh; i++) begin
        max_q[i]  <= '0;
        min_q[i]  <= rcpcs_pkg::MinReset;
        sum_q[i]  <= '0;
        cnt_q[i]  <= '0;
        ctr_q[i]  <= '0;
        last_q[i] <= '0;
      end
    end else begin
      pc_q        <= pc_d;
      idx_q       <= idx_d;
      ok_q        <= ok_d;
      bmode_q     <= bmode_d;
      amode_q     <= amode_d;
      out_valid_q <= out_valid_d;
      span_lo_q   <= span_lo_d;
      span_hi_q   <= span_hi_d;
      thr_num_q   <= thr_num_d;
      thr_den_q   <= thr_den_d;
      roll_num_q  <= roll_num_d;
      pitch_num_q <= pitch_num_d;
      yaw_num_q   <= yaw_num_d;
      axis_den_q  <= axis_den_d;
      max_q       <= max_d;
      min_q       <= min_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      ctr_q       <= ctr_d;
      last_q      <= last_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    w_q        <= w_d;
    acc_q      <= acc_d;
    prod_q     <= prod_d;
    neg_q      <= neg_d;
    ref_q      <= ref_d;
    res_kind_q <= res_kind_d;
    out_ch_q   <= out_ch_d;
    out_ref_q  <= out_ref_d;
    out_ok_q   <= out_ok_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = res_kind_q;
  assign out_channel_o = out_ch_q;
  assign reference_o   = signed'(out_ref_q);
  assign bounds_ok_o   = out_ok_q;

endmodule

// File: hw/rtl/rcpcs_chk.sv
module rcpcs_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic                                result_kind_o,
  input logic [rcpcs_pkg::ChW-1:0]           out_channel_o,
  input logic signed [rcpcs_pkg::WidthW-1:0] reference_o,
  input logic                                bounds_ok_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(result_kind_o) && $stable(out_channel_o) &&
                                     $stable(reference_o) && $stable(bounds_ok_o))
    else $error("output payload changed while stalled");

  // verdicts carry channel zero and a zero reference
  a_verdict_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o |-> (out_channel_o == '0) && (reference_o == '0))
    else $error("malformed bounds verdict");

  // references never flag a pass; throttle stays within 0..255
  a_ref_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_kind_o |->
      !bounds_ok_o && ((out_channel_o != '0) || (reference_o[15:8] == '0)))
    else $error("reference out of form");

endmodule

bind rc_pulse_calibrate_and_scale rcpcs_chk u_rcpcs_chk (.*);
